@@ design/cmap_pkg.sv @@
// Shared types, constants and divider step function for the touch coordinate mapper.
`timescale 1ns / 1ps
`default_nettype none

package cmap_pkg;

    // Coordinate width; register, product and divider widths follow from it
    localparam int COORD_BITS = 16;
    localparam int PROD_W     = 2 * COORD_BITS;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (PROD_W + DIV_STEP - 1) / DIV_STEP;
    // front (swap/flip), multiply, divider stages, output clamp
    localparam int NSTG       = DIV_STAGES + 3;

    localparam int TRACK_BITS = 8;
    localparam int AREA_BITS  = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COORD_BITS-1:0] DISP_W_RST = COORD_BITS'(800);
    localparam logic [COORD_BITS-1:0] DISP_H_RST = COORD_BITS'(480);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [PROD_W-1:0]     prod_t;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PANEL_X_RES    = 3'd0,
        REG_PANEL_Y_RES    = 3'd1,
        REG_FLIP_HALF_TURN = 3'd2,
        REG_DISPLAY_WIDTH  = 3'd3,
        REG_DISPLAY_HEIGHT = 3'd4
    } cfg_reg_t;

    // Mapping setup as seen by the datapath
    typedef struct packed {
        logic   swap;    // portrait panel: exchange axes
        logic   flip;    // 180 degree rotation
        coord_t res_x;   // panel resolution along display x
        coord_t res_y;   // panel resolution along display y
        coord_t disp_w;
        coord_t disp_h;
    } map_cfg_t;

    // One axis leaving the multiply stage
    typedef struct packed {
        prod_t  prod;    // coordinate times display size
        coord_t c;       // coordinate before scaling
    } axis_t;

    // Divider working state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        coord_t rem;
        prod_t  nq;
    } div_state_t;

    // Up to DIV_STEP restoring division steps, nsteps of them active
    function automatic div_state_t div_steps(div_state_t st, coord_t d, int nsteps);
        div_state_t             s;
        logic [COORD_BITS:0]    t;
        s = st;
        for (int k = 0; k < DIV_STEP; k++) begin
            if (k < nsteps) begin
                t    = {s.rem, s.nq[PROD_W-1]};
                s.nq = {s.nq[PROD_W-2:0], 1'b0};
                if (t >= {1'b0, d}) begin
                    t       = t - {1'b0, d};
                    s.nq[0] = 1'b1;
                end
                s.rem = t[COORD_BITS-1:0];
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/cmap_cfg.sv @@
// Configuration registers and derived axis setup of the touch coordinate mapper.
`timescale 1ns / 1ps
`default_nettype none

module cmap_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cmap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cmap_pkg::COORD_BITS-1:0]    cfg_data,
    output cmap_pkg::map_cfg_t                      map_cfg
);
    import cmap_pkg::*;

    coord_t panel_x_reg, panel_x_next;
    coord_t panel_y_reg, panel_y_next;
    logic   flip_reg, flip_next;
    coord_t disp_w_reg, disp_w_next;
    coord_t disp_h_reg, disp_h_next;
    logic   wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        panel_x_next = panel_x_reg;
        panel_y_next = panel_y_reg;
        flip_next    = flip_reg;
        disp_w_next  = disp_w_reg;
        disp_h_next  = disp_h_reg;
        if (wr)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PANEL_X_RES:    panel_x_next = cfg_data;
                REG_PANEL_Y_RES:    panel_y_next = cfg_data;
                REG_FLIP_HALF_TURN: flip_next    = cfg_data[0];
                REG_DISPLAY_WIDTH:  disp_w_next  = cfg_data;
                REG_DISPLAY_HEIGHT: disp_h_next  = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_x_reg <= '0;
            panel_y_reg <= '0;
            flip_reg    <= 1'b0;
            disp_w_reg  <= DISP_W_RST;
            disp_h_reg  <= DISP_H_RST;
        end
        else
        begin
            panel_x_reg <= panel_x_next;
            panel_y_reg <= panel_y_next;
            flip_reg    <= flip_next;
            disp_w_reg  <= disp_w_next;
            disp_h_reg  <= disp_h_next;
        end
    end

    // Portrait when both resolutions known and x narrower than y
    always_comb
    begin
        map_cfg.swap   = (panel_x_reg != '0) && (panel_y_reg != '0) &&
                         (panel_x_reg < panel_y_reg);
        map_cfg.flip   = flip_reg;
        map_cfg.res_x  = map_cfg.swap ? panel_y_reg : panel_x_reg;
        map_cfg.res_y  = map_cfg.swap ? panel_x_reg : panel_y_reg;
        map_cfg.disp_w = disp_w_reg;
        map_cfg.disp_h = disp_h_reg;
    end

endmodule

`default_nettype wire

@@ design/cmap_front.sv @@
// Front stages: axis swap and flip, then multiply by display size.
`timescale 1ns / 1ps
`default_nettype none

module cmap_front (
    input  wire logic                               clk,
    input  wire logic [1:0]                         en,
    input  wire cmap_pkg::map_cfg_t                 map_cfg,
    input  wire logic [cmap_pkg::COORD_BITS-1:0]    raw_x,
    input  wire logic [cmap_pkg::COORD_BITS-1:0]    raw_y,
    output cmap_pkg::axis_t                         axis_x,
    output cmap_pkg::axis_t                         axis_y
);
    import cmap_pkg::*;

    coord_t  sx, sy;
    coord_t  fx, fy;
    coord_t  x0_reg, y0_reg;
    axis_t   ax_reg, ay_reg;

    // Stage 0: swap for portrait panels, optional half-turn (wraps)
    always_comb
    begin
        sx = map_cfg.swap ? raw_y : raw_x;
        sy = map_cfg.swap ? raw_x : raw_y;
        fx = (map_cfg.flip && map_cfg.res_x != '0) ? coord_t'(map_cfg.res_x - sx) : sx;
        fy = (map_cfg.flip && map_cfg.res_y != '0) ? coord_t'(map_cfg.res_y - sy) : sy;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg <= fx;
            y0_reg <= fy;
        end
    end

    // Stage 1: full-width product with the display size
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ax_reg.prod <= PROD_W'(x0_reg) * PROD_W'(map_cfg.disp_w);
            ax_reg.c    <= x0_reg;
            ay_reg.prod <= PROD_W'(y0_reg) * PROD_W'(map_cfg.disp_h);
            ay_reg.c    <= y0_reg;
        end
    end

    assign axis_x = ax_reg;
    assign axis_y = ay_reg;

endmodule

`default_nettype wire

@@ design/cmap_div.sv @@
// Pipelined restoring divider for one axis, DIV_STEP quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none

module cmap_div (
    input  wire logic                               clk,
    input  wire logic [cmap_pkg::DIV_STAGES-1:0]    en,
    input  wire cmap_pkg::axis_t                    axis_in,
    input  wire logic [cmap_pkg::COORD_BITS-1:0]    divisor,
    output logic [cmap_pkg::COORD_BITS-1:0]         quot,
    output logic [cmap_pkg::COORD_BITS-1:0]         c_out
);
    import cmap_pkg::*;

    div_state_t st_reg [DIV_STAGES];
    coord_t     c_reg  [DIV_STAGES];
    div_state_t st_in  [DIV_STAGES];
    coord_t     c_in   [DIV_STAGES];

    // Stage inputs: first stage starts from a zero remainder
    always_comb
    begin
        st_in[0].rem = '0;
        st_in[0].nq  = axis_in.prod;
        c_in[0]      = axis_in.c;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            st_in[i] = st_reg[i-1];
            c_in[i]  = c_reg[i-1];
        end
    end

    // The user must keep the divisor static while items are in flight; the block does not enforce it
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        localparam int NSTEPS = ((PROD_W - i * DIV_STEP) < DIV_STEP) ?
                                (PROD_W - i * DIV_STEP) : DIV_STEP;
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                st_reg[i] <= div_steps(st_in[i], divisor, NSTEPS);
                c_reg[i]  <= c_in[i];
            end
        end
    end

    // Low quotient bits only; upper bits are dropped by the mapping
    assign quot  = st_reg[DIV_STAGES-1].nq[COORD_BITS-1:0];
    assign c_out = c_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ design/touch_coordinate_mapper_core.sv @@
// Top level of the touch coordinate mapper: pipeline control and output clamp.
//
// Usage: raw touch points enter on the point channel (point_valid/point_stall)
// with track_id, raw_x, raw_y and contact_area. Each point gives exactly one
// result on the result channel (result_valid/result_stall): out_track_id,
// screen_x, screen_y and out_area, in input order.
// Configuration registers are written over cfg_valid/cfg_ready with
// cfg_index 0..4 (panel x res, panel y res, flip, display width, display
// height); cfg_ready is always high. Write them only while no point is
// in flight.
// Throughput: one point per cycle while result_stall is low. A point passes,
// in order, through one swap/flip stage, one multiply stage, eight divider
// stages of four quotient bits each, and the clamp/output register.
// When result_stall is high the output holds; empty stages upstream keep
// filling, and point_stall rises only once the stage after the input is
// full and cannot move.
// Reset clears all valid bits and loads the register defaults
// (0, 0, no flip, 800 x 480).
`timescale 1ns / 1ps
`default_nettype none

module touch_coordinate_mapper_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // point channel
    input  wire logic                               point_valid,
    output logic                                    point_stall,
    input  wire logic [cmap_pkg::TRACK_BITS-1:0]    track_id,
    input  wire logic [cmap_pkg::COORD_BITS-1:0]    raw_x,
    input  wire logic [cmap_pkg::COORD_BITS-1:0]    raw_y,
    input  wire logic [cmap_pkg::AREA_BITS-1:0]     contact_area,
    // result channel
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic [cmap_pkg::TRACK_BITS-1:0]         out_track_id,
    output logic [cmap_pkg::COORD_BITS-1:0]         screen_x,
    output logic [cmap_pkg::COORD_BITS-1:0]         screen_y,
    output logic [cmap_pkg::AREA_BITS-1:0]          out_area,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cmap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cmap_pkg::COORD_BITS-1:0]    cfg_data
);
    import cmap_pkg::*;

    typedef struct packed {
        logic [TRACK_BITS-1:0] track;
        logic [AREA_BITS-1:0]  area;
    } pass_t;

    localparam int LAST = NSTG - 1;

    map_cfg_t          map_cfg;
    logic [NSTG-1:0]   v_reg;
    logic [NSTG-1:0]   en;
    pass_t             pass_reg [NSTG];
    axis_t             axis_x, axis_y;
    coord_t            qx, qy, cx, cy;
    coord_t            sx_next, sy_next;

    cmap_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .map_cfg   (map_cfg)
    );

    // Stage enables: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[LAST] = !v_reg[LAST] || !result_stall;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign point_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= point_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Track id and area ride alongside the coordinates
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pass_reg[0].track <= track_id;
            pass_reg[0].area  <= contact_area;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (en[i])
            begin
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    cmap_front u_front (
        .clk     (clk),
        .en      (en[1:0]),
        .map_cfg (map_cfg),
        .raw_x   (raw_x),
        .raw_y   (raw_y),
        .axis_x  (axis_x),
        .axis_y  (axis_y)
    );

    cmap_div u_div_x (
        .clk     (clk),
        .en      (en[DIV_STAGES+1:2]),
        .axis_in (axis_x),
        .divisor (map_cfg.res_x),
        .quot    (qx),
        .c_out   (cx)
    );

    cmap_div u_div_y (
        .clk     (clk),
        .en      (en[DIV_STAGES+1:2]),
        .axis_in (axis_y),
        .divisor (map_cfg.res_y),
        .quot    (qy),
        .c_out   (cy)
    );

    // Skip scaling for unknown or matching resolution, then saturate
    always_comb
    begin
        coord_t vx;
        coord_t vy;
        vx = (map_cfg.res_x == '0 || map_cfg.res_x == map_cfg.disp_w) ? cx : qx;
        vy = (map_cfg.res_y == '0 || map_cfg.res_y == map_cfg.disp_h) ? cy : qy;
        if (map_cfg.disp_w == '0)
            sx_next = '0;
        else if (vx >= map_cfg.disp_w)
            sx_next = map_cfg.disp_w - coord_t'(1);
        else
            sx_next = vx;
        if (map_cfg.disp_h == '0)
            sy_next = '0;
        else if (vy >= map_cfg.disp_h)
            sy_next = map_cfg.disp_h - coord_t'(1);
        else
            sy_next = vy;
    end

    coord_t sx_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign result_valid = v_reg[LAST];
    assign out_track_id = pass_reg[LAST].track;
    assign out_area     = pass_reg[LAST].area;
    assign screen_x     = sx_reg;
    assign screen_y     = sy_reg;

endmodule

`default_nettype wire
